@@ hdl/text_terminal_char_writer_assert.svh @@
// assertion macros for the text terminal character writer checker
`ifndef TEXT_TERMINAL_CHAR_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_CHAR_WRITER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off while in reset
`define TTCW_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define TTCW_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/ttcw_pkg.sv @@
// shared types and constants for the text terminal character writer
package ttcw_pkg;

  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int RROW_W      = 5;
  localparam int RCOL_W      = 7;
  localparam int CCOL_W      = 7;
  localparam int CROW_W      = 5;
  localparam int VIS_FIELD_W = 7;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 1;

  localparam logic [REG_IDX_W-1:0] REG_VISIBLE_COLS = 1'b0;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam int TAB_SPACES = 4;
  localparam int TAB_CNT_W  = $clog2(TAB_SPACES);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_ZERO,
    ST_PUT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    WSRC_SWEEP,
    WSRC_CHAR,
    WSRC_SPACE,
    WSRC_BACK
  } wsrc_e;

  typedef enum logic [1:0] {
    COL_HOLD,
    COL_INC,
    COL_DEC
  } col_op_e;

  typedef struct packed {
    logic    load;
    logic    emit;
    logic    mem_we;
    wsrc_e   wsrc;
    col_op_e col_op;
    logic    sweep_clr;
    logic    sweep_cur;
    logic    sweep_inc;
    logic    set_vld;
    logic    tab_inc;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_nl;
    logic is_bs;
    logic is_tab;
    logic row_vld;
    logic col_zero;
    logic col_lt_vis;
    logic tab_done;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/ttcw_ram.sv @@
// generic single-write, single-read ram with registered read data
module ttcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ttcw_ctrl.sv @@
// sequencing state machine for the text terminal character writer
module ttcw_ctrl import ttcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.wsrc       = WSRC_SWEEP;
    cmd_o.col_op     = COL_HOLD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_FINISH;
        if (sts_i.is_write) begin
          if (sts_i.is_nl) begin
            if (sts_i.row_vld) begin
              cmd_o.sweep_cur = 1'b1;
              state_d         = ST_ZERO;
            end
          end else if (sts_i.is_bs ? !sts_i.col_zero : sts_i.col_lt_vis) begin
            if (sts_i.row_vld) begin
              state_d = ST_PUT;
            end else begin
              cmd_o.sweep_clr = 1'b1;
              state_d         = ST_FILL;
            end
          end
        end
      end
      ST_FILL: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.wsrc      = WSRC_SWEEP;
        cmd_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.set_vld = 1'b1;
          state_d       = ST_PUT;
        end
      end
      ST_ZERO: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.wsrc      = WSRC_SWEEP;
        cmd_o.sweep_inc = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_PUT: begin
        cmd_o.mem_we = 1'b1;
        state_d      = ST_FINISH;
        if (sts_i.is_bs) begin
          cmd_o.wsrc   = WSRC_BACK;
          cmd_o.col_op = COL_DEC;
        end else if (sts_i.is_tab) begin
          cmd_o.wsrc    = WSRC_SPACE;
          cmd_o.col_op  = COL_INC;
          cmd_o.tab_inc = 1'b1;
          if (!sts_i.tab_done) begin
            state_d = ST_PUT;
          end
        end else begin
          cmd_o.wsrc   = WSRC_CHAR;
          cmd_o.col_op = COL_INC;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/ttcw_dpath.sv @@
// cursor, row map, cell ram and result register of the character writer
module ttcw_dpath import ttcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  localparam int VW = $clog2(COLS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   op_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [RROW_W-1:0] read_row_i,
  input  logic [RCOL_W-1:0] read_col_i,
  input  logic [VW-1:0]     vis_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic              out_tready_i,
  output logic              out_valid_o,
  output logic [CCOL_W-1:0] cursor_col_o,
  output logic [CROW_W-1:0] cursor_row_o,
  output logic [CHAR_W-1:0] read_char_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [OP_W-1:0]      op_q;
  logic [CHAR_W-1:0]    code_q;
  logic [RROW_W-1:0]    rrow_q;
  logic [RCOL_W-1:0]    rcol_q;
  logic [VW-1:0]        col_q, col_d;
  logic [RW-1:0]        row_q, row_d;
  logic [RW-1:0]        base_q, base_d;
  logic [ROWS-1:0]      vld_q, vld_d;
  logic [CW-1:0]        sweep_q, sweep_d;
  logic [TAB_CNT_W-1:0] tab_q, tab_d;
  logic                 out_valid_q, out_valid_d;
  logic [CCOL_W-1:0]    out_col_q;
  logic [CROW_W-1:0]    out_row_q;
  logic [CHAR_W-1:0]    out_char_q;

  logic [RW-1:0]     cur_prow, rd_prow, fin_row, base_next;
  logic [VW-1:0]     fin_col;
  logic [RW:0]       nrow_ext;
  logic              is_write, is_clear, is_read, is_nl, wrap, scroll, rd_hit;
  logic [CW-1:0]     wcol;
  logic [CHAR_W-1:0] wdata, rdata, rd_char;
  logic [AW-1:0]     waddr, raddr;

  // logical row to physical row, rotated by the scroll base
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r);
    logic [RW:0] s;
    s = {1'b0, base_q} + {1'b0, r};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  assign cur_prow = phys_row(row_q);
  assign rd_prow  = phys_row(RW'(rrow_q));

  assign is_write = (op_q == OP_WRITE);
  assign is_clear = (op_q == OP_CLEAR);
  assign is_read  = (op_q == OP_READ);
  assign is_nl    = (code_q == CH_NEWLINE);

  always_comb begin
    case (cmd_i.wsrc)
      WSRC_CHAR: begin
        wcol  = CW'(col_q);
        wdata = code_q;
      end
      WSRC_SPACE: begin
        wcol  = CW'(col_q);
        wdata = CH_SPACE;
      end
      WSRC_BACK: begin
        wcol  = CW'(col_q - 1'b1);
        wdata = CH_SPACE;
      end
      default: begin
        wcol  = sweep_q;
        wdata = '0;
      end
    endcase
  end

  assign waddr = AW'(cur_prow) * AW'(COLS) + AW'(wcol);
  assign raddr = AW'(rd_prow) * AW'(COLS) + AW'(CW'(rcol_q));

  ttcw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_hit  = (int'(rrow_q) < ROWS) && (int'(rcol_q) < COLS) && vld_q[rd_prow];
  assign rd_char = (is_read && rd_hit) ? rdata : '0;

  // wrap at the visible width or on a newline, then scroll past the last row
  assign wrap      = is_nl || (col_q >= vis_i);
  assign nrow_ext  = {1'b0, row_q} + (RW+1)'(wrap);
  assign scroll    = (nrow_ext == (RW+1)'(ROWS));
  assign fin_col   = wrap ? '0 : col_q;
  assign fin_row   = scroll ? RW'(ROWS - 1) : nrow_ext[RW-1:0];
  assign base_next = (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;

  assign sts_o.is_write   = is_write;
  assign sts_o.is_nl      = is_nl;
  assign sts_o.is_bs      = (code_q == CH_BACKSPACE);
  assign sts_o.is_tab     = (code_q == CH_TAB);
  assign sts_o.row_vld    = vld_q[cur_prow];
  assign sts_o.col_zero   = (col_q == '0);
  assign sts_o.col_lt_vis = (col_q < vis_i);
  assign sts_o.tab_done   = (tab_q == TAB_CNT_W'(TAB_SPACES - 1))
                          || (({1'b0, col_q} + 1'b1) >= {1'b0, vis_i});
  assign sts_o.sweep_last = (sweep_q == CW'(COLS - 1));
  assign sts_o.out_free   = !out_valid_q || out_tready_i;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    base_d      = base_q;
    vld_d       = vld_q;
    sweep_d     = sweep_q;
    tab_d       = tab_q;
    out_valid_d = out_valid_q;
    case (cmd_i.col_op)
      COL_INC: col_d = col_q + 1'b1;
      COL_DEC: col_d = col_q - 1'b1;
      default: col_d = col_q;
    endcase
    if (cmd_i.sweep_clr) begin
      sweep_d = '0;
    end else if (cmd_i.sweep_cur) begin
      sweep_d = CW'(col_q);
    end else if (cmd_i.sweep_inc) begin
      sweep_d = sweep_q + 1'b1;
    end
    if (cmd_i.load) begin
      tab_d = '0;
    end else if (cmd_i.tab_inc) begin
      tab_d = tab_q + 1'b1;
    end
    if (cmd_i.set_vld) begin
      vld_d[cur_prow] = 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (is_clear) begin
        col_d = '0;
        row_d = '0;
        vld_d = '0;
      end else if (is_write) begin
        col_d = fin_col;
        row_d = fin_row;
        if (scroll) begin
          base_d        = base_next;
          vld_d[base_q] = 1'b0;
        end
      end
    end else if (out_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      vld_q       <= '0;
      sweep_q     <= '0;
      tab_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      base_q      <= base_d;
      vld_q       <= vld_d;
      sweep_q     <= sweep_d;
      tab_q       <= tab_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      code_q <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
    if (cmd_i.emit) begin
      out_col_q  <= CCOL_W'(col_d);
      out_row_q  <= CROW_W'(row_d);
      out_char_q <= rd_char;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign read_char_o  = out_char_q;

endmodule

@@ hdl/text_terminal_char_writer.sv @@
// top level of the text terminal character writer
//
// channel   direction  fields (low bit first)
// s_axis    in         op[1:0] char_code[9:2] read_row[14:10] read_col[21:15]
// m_axis    out        cursor_col[6:0] cursor_row[11:7] read_char[19:12]
// apb       in/out     visible_cols at byte address 0
//
// printable: dispatch, put, finish; tab: a put per space; read, clear, idle: dispatch, finish
// first write to a blank row adds a fill pass that zeroes the row through the ram write port
// newline on a written row zeroes from the cursor column on; scroll and clear need no ram pass
// reset clears per-row valid bits at once, so no clearing pass runs after reset
// one result may wait in the output register while the next item is taken and worked on
module text_terminal_char_writer import ttcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op, char_code, read_row, read_col
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cursor_col, cursor_row, read_char
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int VW = $clog2(COLS + 1);

  logic [VW-1:0]          vis_q, vis_d;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic [VIS_FIELD_W-1:0] wval;
  cmd_t                   cmd;
  sts_t                   sts;
  logic [CCOL_W-1:0]      cursor_col;
  logic [CROW_W-1:0]      cursor_row;
  logic [CHAR_W-1:0]      read_char;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wval    = pwdata[VIS_FIELD_W-1:0];
  assign prdata  = (reg_idx == REG_VISIBLE_COLS) ? APB_DW'(vis_q) : '0;

  always_comb begin
    vis_d = vis_q;
    if (psel && penable && pwrite && pready && (reg_idx == REG_VISIBLE_COLS)
        && (wval != '0) && (int'(wval) <= COLS)) begin
      vis_d = VW'(wval);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= VW'(COLS);
    end else begin
      vis_q <= vis_d;
    end
  end

  ttcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ttcw_dpath #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tdata[1:0]),
    .char_code_i (s_axis_tdata[9:2]),
    .read_row_i  (s_axis_tdata[14:10]),
    .read_col_i  (s_axis_tdata[21:15]),
    .vis_i       (vis_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_tready_i(m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cursor_col_o(cursor_col),
    .cursor_row_o(cursor_row),
    .read_char_o (read_char)
  );

  assign m_axis_tdata = {4'b0, read_char, cursor_row, cursor_col};

endmodule

@@ hdl/ttcw_checker.sv @@
// port-level checks for the text terminal character writer, bound to the top
`include "text_terminal_char_writer_assert.svh"

module ttcw_port_checker import ttcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] pend_q, pend_d;
  logic       s_acc, m_acc, out_stall, cursor_ok;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign m_acc     = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign cursor_ok = (int'(m_axis_tdata[6:0]) < COLS) && (int'(m_axis_tdata[11:7]) < ROWS);

  // transactions taken in but not yet delivered
  always_comb begin
    pend_d = pend_q + 2'(s_acc) - 2'(m_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `TTCW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid, "result dropped")
  `TTCW_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata), "result changed")
  `TTCW_ASSERT_NOW(a_cursor_range, clk_i, rst_ni, m_axis_tvalid, cursor_ok, "cursor off screen")
  `TTCW_ASSERT_NOW(a_no_orphan, clk_i, rst_ni, m_axis_tvalid, pend_q != 2'd0, "orphan result")
  `TTCW_ASSERT_NOW(a_two_in_flight, clk_i, rst_ni, pend_q == 2'd2, !s_axis_tready, "third taken")

endmodule

bind text_terminal_char_writer ttcw_port_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_checker (.*);

@@ dv/ttcw_checker.sv @@
// checker for the text terminal character writer: tracks the screen and compares every result
module ttcw_checker import ttcw_pkg::*; #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // op, char_code, read_row, read_col
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cursor_col, cursor_row, read_char
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  input  logic [APB_DW-1:0]      prdata,
  input  logic                   pready,
  output int                     mismatches,
  output int                     reports_seen,
  output int                     reports_pending,
  output int                     scrolls
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RCOL_W-1:0] read_col;
    logic [RROW_W-1:0] read_row;
    logic [CHAR_W-1:0] char_code;
    logic [OP_W-1:0]   op;
  } keystroke_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [CROW_W-1:0] cursor_row;
    logic [CCOL_W-1:0] cursor_col;
  } cursor_report_t;

  logic [CHAR_W-1:0] screen [ROWS][COLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  int unsigned       width;
  cursor_report_t    expected_reports [$];

  function automatic void blank_screen();
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++)
        screen[r][c] = '0;
  endfunction

  function automatic void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("%t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endfunction

  function automatic void type_char(logic [CHAR_W-1:0] code);
    int unsigned k;
    if (code == CH_NEWLINE) begin
      for (k = cur_col; k < COLS; k++)
        screen[cur_row][k] = '0;
      cur_col = 0;
      cur_row++;
    end else if (code == CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        screen[cur_row][cur_col] = CH_SPACE;
      end
    end else if (code == CH_TAB) begin
      for (k = 0; k < TAB_SPACES && cur_col < width; k++) begin
        screen[cur_row][cur_col] = CH_SPACE;
        cur_col++;
      end
    end else if (cur_col < width) begin
      screen[cur_row][cur_col] = code;
      cur_col++;
    end
    if (cur_col >= width) begin
      cur_col = 0;
      cur_row++;
    end
    // past the last row: everything moves up and the bottom row is blanked
    if (cur_row >= ROWS) begin
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLS; c++)
          screen[r][c] = screen[r+1][c];
      for (int c = 0; c < COLS; c++)
        screen[ROWS-1][c] = '0;
      cur_row = ROWS - 1;
      scrolls++;
    end
  endfunction

  function automatic cursor_report_t predict_report(keystroke_t ks);
    cursor_report_t rep;
    rep = '0;
    case (ks.op)
      OP_WRITE: type_char(ks.char_code);
      OP_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      OP_READ: begin
        if (ks.read_row < ROWS && ks.read_col < COLS)
          rep.read_char = screen[ks.read_row][ks.read_col];
      end
      default: ;
    endcase
    rep.cursor_col = cur_col[CCOL_W-1:0];
    rep.cursor_row = cur_row[CROW_W-1:0];
    return rep;
  endfunction

  function automatic void check_report(cursor_report_t got);
    cursor_report_t exp_r;
    if (expected_reports.size() == 0) begin
      note_mismatch("unexpected result, cursor_col", 0, got.cursor_col);
    end else begin
      exp_r = expected_reports.pop_front();
      if (got.cursor_col != exp_r.cursor_col)
        note_mismatch("cursor_col", exp_r.cursor_col, got.cursor_col);
      if (got.cursor_row != exp_r.cursor_row)
        note_mismatch("cursor_row", exp_r.cursor_row, got.cursor_row);
      if (got.read_char != exp_r.read_char)
        note_mismatch("read_char", exp_r.read_char, got.read_char);
    end
  endfunction

  initial begin
    mismatches      = 0;
    reports_seen    = 0;
    reports_pending = 0;
    scrolls         = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_screen();
      cur_col = 0;
      cur_row = 0;
      width   = COLS;
      expected_reports.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_report(m_axis_tdata[CHAR_W+CROW_W+CCOL_W-1:0]);
        reports_seen++;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(predict_report(s_axis_tdata[$bits(keystroke_t)-1:0]));
      if (psel && penable && pready && paddr[APB_AW-1:2] == REG_VISIBLE_COLS) begin
        if (pwrite) begin
          if (pwdata[VIS_FIELD_W-1:0] != 0 && pwdata[VIS_FIELD_W-1:0] <= COLS)
            width = 32'(pwdata[VIS_FIELD_W-1:0]);
        end else if (prdata != APB_DW'(width)) begin
          note_mismatch("visible_cols readback", width, prdata);
        end
      end
      reports_pending = expected_reports.size();
    end
  end

endmodule

@@ dv/tb_text_terminal_char_writer.sv @@
// testbench top for the text terminal character writer: stimulus, flow control and verdict
module tb_text_terminal_char_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import ttcw_pkg::*;

  localparam int ROWS        = 25;
  localparam int COLS        = 80;
  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [OP_W-1:0]   OP_SPARE          = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_VISIBLE_COLS = {REG_VISIBLE_COLS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE        = 3'd4;

  typedef struct packed {
    logic [RCOL_W-1:0] read_col;
    logic [RROW_W-1:0] read_row;
    logic [CHAR_W-1:0] char_code;
    logic [OP_W-1:0]   op;
  } keystroke_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // op, char_code, read_row, read_col
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // cursor_col, cursor_row, read_char
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_AW-1:0]      paddr         = '0;
  logic [APB_DW-1:0]      pwdata        = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  int mismatches;
  int reports_seen;
  int reports_pending;
  int scrolls;
  int n_sent     = 0;
  int n_settings = 0;
  int ready_left = 0;
  int cycles;

  text_terminal_char_writer #(.ROWS(ROWS), .COLS(COLS)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ttcw_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .reports_seen    (reports_seen),
    .reports_pending (reports_pending),
    .scrolls         (scrolls)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver back-pressure: runs of ready and stall, mostly short
  always @(posedge clk_i) begin
    int r;
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(1, 8);
      end else if (r < 90) begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(1, 3);
      end else if (r < 96) begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(10, 40);
      end else begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(50, 200);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic keystroke_t key_of(logic [OP_W-1:0] op, logic [CHAR_W-1:0] code,
                                        logic [RROW_W-1:0] row, logic [RCOL_W-1:0] col);
    keystroke_t ks;
    ks.op        = op;
    ks.char_code = code;
    ks.read_row  = row;
    ks.read_col  = col;
    return ks;
  endfunction

  function automatic keystroke_t random_keystroke();
    keystroke_t ks;
    int r;
    int c;
    ks.char_code = CHAR_W'($urandom_range(0, 255));
    ks.read_row  = RROW_W'($urandom_range(0, 31));
    ks.read_col  = RCOL_W'($urandom_range(0, 127));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      ks.op = OP_WRITE;
      c = $urandom_range(0, 99);
      if (c < 12)      ks.char_code = CH_NEWLINE;
      else if (c < 20) ks.char_code = CH_BACKSPACE;
      else if (c < 27) ks.char_code = CH_TAB;
      else if (c < 90) ks.char_code = CHAR_W'($urandom_range(33, 126));
    end else if (r < 94) begin
      ks.op = OP_READ;
      if ($urandom_range(0, 9) != 0) begin
        ks.read_row = RROW_W'($urandom_range(0, ROWS - 1));
        ks.read_col = RCOL_W'($urandom_range(0, COLS - 1));
      end
    end else if (r < 95) begin
      ks.op = OP_CLEAR;
    end else begin
      ks.op = OP_SPARE;
    end
    return ks;
  endfunction

  task automatic send_keystroke(input keystroke_t ks, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(ks);
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic send_all(input keystroke_t seq [$]);
    foreach (seq[i])
      send_keystroke(seq[i], pick_gap());
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (reports_seen < n_sent) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_width(input logic [APB_DW-1:0] value);
    apb_access(1'b1, ADDR_VISIBLE_COLS, value);
    n_settings++;
  endtask

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_text_terminal_char_writer: errors");
    $finish;
  end

  initial begin
    keystroke_t seq [$];
    int widths [7];
    logic burst;
    widths = '{80, 1, 20, 7, 80, 33, 79};
    burst  = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width, every kind of character and the read corners
    seq = {};
    seq.push_back(key_of(OP_READ,  8'h00,        5'd0,  7'd0));
    seq.push_back(key_of(OP_WRITE, 8'h41,        5'd31, 7'd127));
    seq.push_back(key_of(OP_WRITE, 8'h00,        5'd0,  7'd0));
    seq.push_back(key_of(OP_WRITE, 8'hFF,        5'd31, 7'd127));
    seq.push_back(key_of(OP_WRITE, CH_TAB,       5'd0,  7'd0));
    seq.push_back(key_of(OP_WRITE, CH_BACKSPACE, 5'd0,  7'd0));
    seq.push_back(key_of(OP_WRITE, CH_NEWLINE,   5'd0,  7'd0));
    seq.push_back(key_of(OP_WRITE, CH_BACKSPACE, 5'd0,  7'd0));
    seq.push_back(key_of(OP_READ,  8'h00,        5'd0,  7'd0));
    seq.push_back(key_of(OP_READ,  8'hFF,        5'd0,  7'd1));
    seq.push_back(key_of(OP_READ,  8'h00,        5'd24, 7'd79));
    seq.push_back(key_of(OP_READ,  8'h00,        5'd31, 7'd127));
    seq.push_back(key_of(OP_READ,  8'h00,        5'd25, 7'd0));
    seq.push_back(key_of(OP_READ,  8'h00,        5'd0,  7'd80));
    seq.push_back(key_of(OP_SPARE, 8'hFF,        5'd31, 7'd127));
    seq.push_back(key_of(OP_CLEAR, 8'h00,        5'd0,  7'd0));
    seq.push_back(key_of(OP_READ,  8'h00,        5'd0,  7'd0));
    send_all(seq);
    wait_drained();

    // out of range widths are dropped, upper data bits are ignored
    set_width(0);
    set_width(81);
    set_width(127);
    apb_access(1'b0, ADDR_VISIBLE_COLS, '0);
    set_width(32'hA5A5_A514);
    apb_access(1'b1, ADDR_SPARE, 32'd5);
    apb_access(1'b0, ADDR_VISIBLE_COLS, '0);
    set_width(80);

    seq = {};
    for (int i = 0; i < 5; i++)
      seq.push_back(key_of(OP_WRITE, CHAR_W'(8'h61 + i), 5'd0, 7'd0));
    send_all(seq);
    wait_drained();

    // width shrunk below the cursor
    set_width(3);
    seq = {};
    seq.push_back(key_of(OP_WRITE, 8'h5A,   5'd0, 7'd0));
    seq.push_back(key_of(OP_WRITE, CH_TAB,  5'd0, 7'd0));
    send_all(seq);
    wait_drained();

    set_width(1);
    seq = {};
    seq.push_back(key_of(OP_WRITE, 8'h71, 5'd0, 7'd0));
    seq.push_back(key_of(OP_READ,  8'h00, 5'd1, 7'd0));
    send_all(seq);
    wait_drained();

    foreach (widths[p]) begin
      set_width(widths[p]);
      if (p == 2)
        apb_access(1'b0, ADDR_VISIBLE_COLS, '0);
      for (int i = 0; i < 100; i++) begin
        if (i % 25 == 0)
          burst = ($urandom_range(0, 3) == 0);
        send_keystroke(random_keystroke(), burst ? 0 : pick_gap());
      end
      wait_drained();
    end

    repeat (50) @(posedge clk_i);

    $display("tb: %0d transactions sent, %0d results checked, %0d width settings",
             n_sent, reports_seen, n_settings);
    $display("tb: %0d scrolls, %0d mismatches, %0d results missing",
             scrolls, mismatches, reports_pending);
    if (mismatches == 0 && reports_pending == 0) begin
      $display("tb_text_terminal_char_writer: clean");
    end else begin
      $display("tb_text_terminal_char_writer: errors");
    end
    $finish;
  end

endmodule
